// ===== src/assert_macros.svh =====
// assertion macros used by indexed_max_heap_queue
// no dependencies; include guard keeps a single definition
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/ihq_pkg.sv =====
// package for the indexed max-heap queue: sizes, codes, entry type, ordering
// no dependencies
package ihq_pkg;
    localparam int CAPACITY      = 256;
    localparam int KEY_COUNT     = 256;
    localparam int PRIORITY_BITS = 32;
    localparam int KEY_W         = 8;
    localparam int PRIO_W        = 32;
    localparam int OP_W          = 3;
    localparam int ST_W          = 3;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE  = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_UPD = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd3;
    localparam logic [OP_W-1:0] OP_EXTRACT = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_EXISTS    = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [KEY_W-1:0]         key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // a orders strictly below b
    function automatic logic entry_less(input t_entry a, input t_entry b);
        logic r;
        if (a.prio != b.prio) begin
            r = a.prio < b.prio;
        end else begin
            r = a.key < b.key;
        end
        return r;
    endfunction
endpackage

// ===== src/ihq_if.sv =====
// channel interfaces for the indexed max-heap queue
// depends on ihq_pkg
interface ihq_in_if;
    logic                       valid;
    logic                       ready;
    logic [ihq_pkg::OP_W-1:0]   operation;
    logic [ihq_pkg::KEY_W-1:0]  entry_key;
    logic [ihq_pkg::PRIO_W-1:0] entry_priority;
    modport source(output valid, output operation, output entry_key,
                   output entry_priority, input ready);
    modport sink(input valid, input operation, input entry_key,
                 input entry_priority, output ready);
endinterface

interface ihq_out_if;
    logic                       valid;
    logic                       ready;
    logic [ihq_pkg::ST_W-1:0]   status;
    logic [ihq_pkg::KEY_W-1:0]  result_key;
    logic [ihq_pkg::PRIO_W-1:0] result_priority;
    logic [ihq_pkg::CNT_W-1:0]  entry_count;
    modport source(output valid, output status, output result_key,
                   output result_priority, output entry_count, input ready);
    modport sink(input valid, input status, input result_key,
                 input result_priority, input entry_count, output ready);
endinterface

// ===== src/ihq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/indexed_max_heap_queue.sv =====
// Indexed binary max-heap of (priority, key) entries, served largest pair
// first, with a key-to-slot map for find and update by key. One transaction
// is worked at a time; a new one can be taken in the cycle its predecessor's
// result is taken. The heap ram has a single read port, so each level reads
// the parent, or the two children one after the other. The map valid bits
// are cleared at reset, so no clearing pass is needed.
// depends on ihq_pkg, ihq_if, ihq_ram, assert_macros.svh
`include "assert_macros.svh"
module indexed_max_heap_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ihq_in_if.sink    i_in,
    ihq_out_if.source o_out
);
    localparam int IW = ihq_pkg::IDX_W;
    localparam int CW = ihq_pkg::IDX_W + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UD_SLOT = 4'd1;
    localparam logic [3:0] S_FD_SLOT = 4'd2;
    localparam logic [3:0] S_FD_HEAP = 4'd3;
    localparam logic [3:0] S_EX_TOP  = 4'd4;
    localparam logic [3:0] S_EX_LAST = 4'd5;
    localparam logic [3:0] S_UP_RD   = 4'd6;
    localparam logic [3:0] S_UP_CMP  = 4'd7;
    localparam logic [3:0] S_DN_RL   = 4'd8;
    localparam logic [3:0] S_DN_RR   = 4'd9;
    localparam logic [3:0] S_DN_CMP  = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;

    logic [3:0]                     r_state, n_state;
    logic                           r_op_upd, n_op_upd;
    logic [IW-1:0]                  r_idx, n_idx;
    ihq_pkg::t_entry                r_cur, n_cur;
    ihq_pkg::t_entry                r_left, n_left;
    ihq_pkg::t_entry                r_res, n_res;
    logic [ihq_pkg::ST_W-1:0]       r_status, n_status;
    logic [ihq_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [ihq_pkg::KEY_COUNT-1:0]  r_valid, n_valid;
    logic                           r_out_valid, n_out_valid;

    logic                           heap_we;
    logic [IW-1:0]                  heap_waddr, heap_raddr;
    ihq_pkg::t_entry                heap_wdata, heap_rd;
    logic [ihq_pkg::ENTRY_W-1:0]    heap_rdata;
    logic                           slot_we;
    logic [ihq_pkg::KEY_W-1:0]      slot_waddr, slot_raddr;
    logic [IW-1:0]                  slot_wdata, slot_rdata;

    logic                           in_acc;
    logic [ihq_pkg::OP_W-1:0]       op;
    logic                           key_ok, present;
    ihq_pkg::t_entry                in_entry;
    logic [IW-1:0]                  parent;
    logic [CW-1:0]                  lc, rc;
    ihq_pkg::t_entry                best;
    logic [IW-1:0]                  best_idx;

    // heap entries and key-to-slot map
    ihq_ram #(.WIDTH(ihq_pkg::ENTRY_W), .DEPTH(ihq_pkg::CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    ihq_ram #(.WIDTH(IW), .DEPTH(ihq_pkg::KEY_COUNT)) u_slot (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // handshake and decode
    assign heap_rd         = heap_rdata;
    assign i_in.ready      = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc          = i_in.valid && i_in.ready;
    assign key_ok          = 32'(i_in.entry_key) < 32'(ihq_pkg::KEY_COUNT);
    assign present         = key_ok && r_valid[i_in.entry_key];
    assign in_entry.prio   = i_in.entry_priority[ihq_pkg::PRIORITY_BITS-1:0];
    assign in_entry.key    = i_in.entry_key;
    assign parent          = IW'((r_idx - IW'(1)) >> 1);
    assign lc              = {1'b0, r_idx, 1'b1};
    assign rc              = lc + CW'(1);

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.result_key      = r_res.key;
    assign o_out.result_priority = ihq_pkg::PRIO_W'(r_res.prio);
    assign o_out.entry_count     = r_cnt;

    // pick the largest of the hole entry and its children
    always_comb begin
        best     = r_cur;
        best_idx = r_idx;
        if (ihq_pkg::entry_less(best, r_left)) begin
            best     = r_left;
            best_idx = lc[IW-1:0];
        end
        if (rc < CW'(r_cnt) && ihq_pkg::entry_less(best, heap_rd)) begin
            best     = heap_rd;
            best_idx = rc[IW-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op_upd    = r_op_upd;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_left      = r_left;
        n_res       = r_res;
        n_status    = r_status;
        n_cnt       = r_cnt;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        heap_we     = 1'b0;
        heap_waddr  = r_idx;
        heap_wdata  = r_cur;
        heap_raddr  = '0;
        slot_we     = 1'b0;
        slot_waddr  = r_cur.key;
        slot_wdata  = r_idx;
        slot_raddr  = i_in.entry_key;
        op          = i_in.operation;
        if (op == ihq_pkg::OP_ADD_UPD) begin
            op = present ? ihq_pkg::OP_UPDATE : ihq_pkg::OP_ADD;
        end
        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cur       = in_entry;
                    n_res       = '0;
                    n_status    = ihq_pkg::ST_OK;
                    n_out_valid = 1'b1;
                    unique case (op)
                        ihq_pkg::OP_ADD: begin
                            if (!key_ok) begin
                                n_status = ihq_pkg::ST_NOT_FOUND;
                            end else if (present) begin
                                n_status = ihq_pkg::ST_EXISTS;
                            end else if (32'(r_cnt) >= 32'(ihq_pkg::CAPACITY)) begin
                                n_status = ihq_pkg::ST_FULL;
                            end else begin
                                n_valid[i_in.entry_key] = 1'b1;
                                n_cnt       = r_cnt + ihq_pkg::CNT_W'(1);
                                n_idx       = r_cnt[IW-1:0];
                                n_res       = in_entry;
                                n_op_upd    = 1'b0;
                                n_out_valid = 1'b0;
                                n_state     = S_UP_RD;
                            end
                        end
                        ihq_pkg::OP_UPDATE: begin
                            if (!present) begin
                                n_status = ihq_pkg::ST_NOT_FOUND;
                            end else begin
                                n_res       = in_entry;
                                n_op_upd    = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = S_UD_SLOT;
                            end
                        end
                        ihq_pkg::OP_FIND: begin
                            if (!present) begin
                                n_status = ihq_pkg::ST_NOT_FOUND;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_FD_SLOT;
                            end
                        end
                        ihq_pkg::OP_EXTRACT: begin
                            if (r_cnt == '0) begin
                                n_status = ihq_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = S_EX_TOP;
                            end
                        end
                        default: begin
                            n_status = ihq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_UD_SLOT: begin
                n_idx   = slot_rdata;
                n_state = S_UP_RD;
            end
            S_FD_SLOT: begin
                heap_raddr = slot_rdata;
                n_state    = S_FD_HEAP;
            end
            S_FD_HEAP: begin
                n_res       = heap_rd;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_EX_TOP: begin
                n_res      = heap_rd;
                heap_raddr = IW'(r_cnt - ihq_pkg::CNT_W'(1));
                n_state    = S_EX_LAST;
            end
            S_EX_LAST: begin
                n_cur              = heap_rd;
                n_valid[r_res.key] = 1'b0;
                n_cnt              = r_cnt - ihq_pkg::CNT_W'(1);
                n_idx              = '0;
                if (r_cnt == ihq_pkg::CNT_W'(1)) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_DN_RL;
                end
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    n_state = r_op_upd ? S_DN_RL : S_FIN;
                end else begin
                    heap_raddr = parent;
                    n_state    = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (ihq_pkg::entry_less(heap_rd, r_cur)) begin
                    // parent moves down into the hole
                    heap_we    = 1'b1;
                    heap_wdata = heap_rd;
                    slot_we    = 1'b1;
                    slot_waddr = heap_rd.key;
                    n_idx      = parent;
                    n_state    = S_UP_RD;
                end else begin
                    n_state = r_op_upd ? S_DN_RL : S_FIN;
                end
            end
            S_DN_RL: begin
                if (lc >= CW'(r_cnt)) begin
                    n_state = S_FIN;
                end else begin
                    heap_raddr = lc[IW-1:0];
                    n_state    = S_DN_RR;
                end
            end
            S_DN_RR: begin
                n_left     = heap_rd;
                heap_raddr = rc[IW-1:0];
                n_state    = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (best_idx != r_idx) begin
                    // larger child moves up into the hole
                    heap_we    = 1'b1;
                    heap_wdata = best;
                    slot_we    = 1'b1;
                    slot_waddr = best.key;
                    n_idx      = best_idx;
                    n_state    = S_DN_RL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                heap_we     = 1'b1;
                slot_we     = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_op_upd <= n_op_upd;
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_res    <= n_res;
        r_status <= n_status;
    end

    `ASSERT_SAME(a_cnt_cap, i_clk, i_rst_n, 1'b1,
        32'(r_cnt) <= 32'(ihq_pkg::CAPACITY))
    `ASSERT_NEXT(a_out_clear, i_clk, i_rst_n, o_out.valid && o_out.ready && !in_acc,
        !r_out_valid)
    `ASSERT_NEXT(a_busy_no_out, i_clk, i_rst_n, r_state != S_IDLE,
        !r_out_valid || (r_state == S_IDLE))
    `ASSERT_NEXT(a_cnt_step, i_clk, i_rst_n, 1'b1,
        (r_cnt == $past(r_cnt)) || (r_cnt == $past(r_cnt) + ihq_pkg::CNT_W'(1))
        || (r_cnt == $past(r_cnt) - ihq_pkg::CNT_W'(1)))
endmodule

// ===== tb/sv/indexed_max_heap_queue_checker.sv =====
// checker for the indexed max-heap queue: watches both channels, predicts each result
// with its own heap model and compares field by field; depends on ihq_pkg and ihq_if
`timescale 1ns / 1ps
module indexed_max_heap_queue_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    ihq_in_if                      i_in,
    ihq_out_if                     i_out,
    output int                     o_fail_count,
    output int                     o_pending
);
    typedef struct packed {
        logic [ihq_pkg::ST_W-1:0]   status;
        logic [ihq_pkg::KEY_W-1:0]  rkey;
        logic [ihq_pkg::PRIO_W-1:0] rprio;
        logic [ihq_pkg::CNT_W-1:0]  count;
    } t_answer;

    // model state
    logic [ihq_pkg::PRIO_W-1:0] mdl_prio [ihq_pkg::CAPACITY];
    logic [ihq_pkg::KEY_W-1:0]  mdl_key  [ihq_pkg::CAPACITY];
    int                         mdl_slot [ihq_pkg::KEY_COUNT];
    bit                         mdl_held [ihq_pkg::KEY_COUNT];
    int                         mdl_count;
    t_answer                    answer_q[$];
    int                         fails;

    assign o_fail_count = fails;
    assign o_pending    = answer_q.size();

    // strict ordering of two heap slots by (priority, key)
    function automatic bit slot_below(int a, int b);
        if (mdl_prio[a] != mdl_prio[b]) return mdl_prio[a] < mdl_prio[b];
        return mdl_key[a] < mdl_key[b];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [ihq_pkg::PRIO_W-1:0] tp;
        logic [ihq_pkg::KEY_W-1:0]  tk;
        tp = mdl_prio[a]; mdl_prio[a] = mdl_prio[b]; mdl_prio[b] = tp;
        tk = mdl_key[a];  mdl_key[a]  = mdl_key[b];  mdl_key[b]  = tk;
        mdl_slot[mdl_key[a]] = a;
        mdl_slot[mdl_key[b]] = b;
    endfunction

    function automatic int climb(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!slot_below(p, i)) break;
            swap_slots(i, p);
            i = p;
        end
        return i;
    endfunction

    function automatic void descend(int i);
        int best;
        forever begin
            best = i;
            if (2*i+1 < mdl_count && slot_below(best, 2*i+1)) best = 2*i+1;
            if (2*i+2 < mdl_count && slot_below(best, 2*i+2)) best = 2*i+2;
            if (best == i) return;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    // predict the answer to one operation and update the model
    function automatic t_answer heap_operate(logic [ihq_pkg::OP_W-1:0] op,
                                             logic [ihq_pkg::KEY_W-1:0] k,
                                             logic [ihq_pkg::PRIO_W-1:0] pr);
        t_answer a;
        bit present;
        int s;
        a = '0;
        present = mdl_held[k];
        if (op == ihq_pkg::OP_ADD_UPD) op = present ? ihq_pkg::OP_UPDATE : ihq_pkg::OP_ADD;
        case (op)
            ihq_pkg::OP_ADD: begin
                if (present) a.status = ihq_pkg::ST_EXISTS;
                else if (mdl_count >= ihq_pkg::CAPACITY) a.status = ihq_pkg::ST_FULL;
                else begin
                    s = mdl_count;
                    mdl_prio[s] = pr; mdl_key[s] = k;
                    mdl_slot[k] = s; mdl_held[k] = 1;
                    mdl_count++;
                    void'(climb(s));
                    a.rkey = k; a.rprio = pr;
                end
            end
            ihq_pkg::OP_UPDATE: begin
                if (!present) a.status = ihq_pkg::ST_NOT_FOUND;
                else begin
                    s = mdl_slot[k];
                    mdl_prio[s] = pr;
                    descend(climb(s));
                    a.rkey = k; a.rprio = pr;
                end
            end
            ihq_pkg::OP_FIND: begin
                if (!present) a.status = ihq_pkg::ST_NOT_FOUND;
                else begin
                    a.rkey = mdl_key[mdl_slot[k]];
                    a.rprio = mdl_prio[mdl_slot[k]];
                end
            end
            ihq_pkg::OP_EXTRACT: begin
                if (mdl_count == 0) a.status = ihq_pkg::ST_EMPTY;
                else begin
                    s = mdl_count - 1;
                    swap_slots(0, s);
                    a.rkey = mdl_key[s]; a.rprio = mdl_prio[s];
                    mdl_count = s;
                    mdl_held[a.rkey] = 0;
                    descend(0);
                end
            end
            default: a.status = ihq_pkg::ST_OK;
        endcase
        a.count = ihq_pkg::CNT_W'(mdl_count);
        return a;
    endfunction

    // watch the channels, predict on input transaction, compare on output transaction
    always @(posedge i_clk) begin
        t_answer got, want;
        if (!i_rst_n) begin
            mdl_count = 0;
            foreach (mdl_held[i]) mdl_held[i] = 0;
            answer_q.delete();
            fails = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.status, i_out.result_key, i_out.result_priority,
                       i_out.entry_count};
                if (answer_q.size() == 0) begin
                    $error("unexpected result transaction");
                    fails++;
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.rkey !== want.rkey) begin
                        $error("result_key: expected %0d actual %0d", want.rkey, got.rkey);
                        fails++;
                    end
                    if (got.rprio !== want.rprio) begin
                        $error("result_priority: expected %0h actual %0h",
                               want.rprio, got.rprio);
                        fails++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d actual %0d", want.count, got.count);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                answer_q.insert(answer_q.size(),
                                heap_operate(i_in.operation, i_in.entry_key,
                                             i_in.entry_priority));
        end
    end
endmodule

// ===== tb/sv/indexed_max_heap_queue_tb.sv =====
// top of the indexed max-heap queue testbench: clock, reset, stimulus and verdict
// depends on ihq_pkg, ihq_if, the block and indexed_max_heap_queue_checker
`timescale 1ns / 1ps
module indexed_max_heap_queue_tb;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    bit   calm;

    ihq_in_if  in_ch();
    ihq_out_if out_ch();

    indexed_max_heap_queue u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    indexed_max_heap_queue_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.entry_key = '0;
        in_ch.entry_priority = '0;
        out_ch.ready = 1'b0;
    end

    // result side stalls at random, except in the calm stretch
    always @(posedge i_clk)
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // send one transaction, with a random idle gap first unless calm
    task automatic send_op(logic [ihq_pkg::OP_W-1:0] op, logic [ihq_pkg::KEY_W-1:0] k,
                           logic [ihq_pkg::PRIO_W-1:0] pr);
        bit rdy;
        while (!calm && $urandom_range(99) < 17) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.entry_key <= k;
        in_ch.entry_priority <= pr;
        // ready is settled between the falling and the next rising edge
        forever begin
            @(negedge i_clk);
            rdy = in_ch.ready;
            @(posedge i_clk);
            if (rdy) break;
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // random operation mix: mostly valid work over a key pool of the given span
    task automatic random_ops(int n, int key_span, int add_bias);
        logic [ihq_pkg::OP_W-1:0] op;
        logic [ihq_pkg::PRIO_W-1:0] pr;
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < add_bias) op = ihq_pkg::OP_ADD;
            else if (r < add_bias + 12) op = ihq_pkg::OP_UPDATE;
            else if (r < add_bias + 30) op = ihq_pkg::OP_ADD_UPD;
            else if (r < add_bias + 45) op = ihq_pkg::OP_FIND;
            else if (r < 97) op = ihq_pkg::OP_EXTRACT;
            else op = ihq_pkg::OP_W'($urandom_range(7, 5));
            case ($urandom_range(3))
                0: pr = $urandom;
                1: pr = $urandom_range(3);
                2: pr = 32'hFFFF_FFFF - $urandom_range(2);
                default: pr = $urandom_range(1000);
            endcase
            send_op(op, ihq_pkg::KEY_W'($urandom_range(key_span)), pr);
        end
    endtask

    initial begin
        calm = 1'b0;
        quiet_cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, absent keys, extremes, ties, duplicates, unknown codes
        send_op(ihq_pkg::OP_EXTRACT, 8'd0, '0);
        send_op(ihq_pkg::OP_FIND, 8'd7, '0);
        send_op(ihq_pkg::OP_UPDATE, 8'd7, 32'd5);
        send_op(ihq_pkg::OP_ADD, 8'd0, 32'd0);
        send_op(ihq_pkg::OP_ADD, 8'd255, 32'hFFFF_FFFF);
        send_op(ihq_pkg::OP_ADD, 8'd255, 32'd1);
        send_op(ihq_pkg::OP_ADD, 8'd10, 32'd0);
        send_op(ihq_pkg::OP_ADD, 8'd20, 32'hFFFF_FFFF);
        send_op(ihq_pkg::OP_ADD_UPD, 8'd30, 32'h8000_0000);
        send_op(ihq_pkg::OP_ADD_UPD, 8'd10, 32'h7FFF_FFFF);
        send_op(ihq_pkg::OP_FIND, 8'd10, '0);
        send_op(ihq_pkg::OP_UPDATE, 8'd255, 32'd0);
        send_op(3'd5, 8'hAA, 32'h5555_5555);
        send_op(3'd6, 8'h55, 32'hAAAA_AAAA);
        send_op(3'd7, 8'hFF, 32'hFFFF_FFFF);
        repeat (7) send_op(ihq_pkg::OP_EXTRACT, 8'd0, '0);

        // calm stretch, then a pause until drained
        calm = 1'b1;
        random_ops(60, 15, 35);
        calm = 1'b0;
        wait_drained();

        // add every key so the heap fills up, then drain partly
        for (int k = 0; k < ihq_pkg::CAPACITY; k++)
            send_op(ihq_pkg::OP_ADD, ihq_pkg::KEY_W'(k), $urandom);
        send_op(ihq_pkg::OP_ADD_UPD, 8'd3, 32'd9);
        send_op(ihq_pkg::OP_ADD, 8'd3, 32'd1);
        wait_drained();
        random_ops(40, 255, 5);
        repeat (80) send_op(ihq_pkg::OP_EXTRACT, 8'd0, '0);

        random_ops(60, 31, 30);
        wait_drained();

        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
